[rtl/b64d_pkg.sv]
// shared types, character codes and the character-to-sextet decode function
// for the base64 stream decoder; no dependencies
package b64d_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned SextW     = 6;
  localparam int unsigned AccW      = 18;
  localparam int unsigned WordW     = 24;
  localparam int unsigned BurstLen  = 3;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoAw    = 2;

  localparam logic [ByteW-1:0] CharNul    = 8'h00;
  localparam logic [ByteW-1:0] CharUpperA = 8'h41;
  localparam logic [ByteW-1:0] CharUpperZ = 8'h5a;
  localparam logic [ByteW-1:0] CharLowerA = 8'h61;
  localparam logic [ByteW-1:0] CharLowerZ = 8'h7a;
  localparam logic [ByteW-1:0] CharZero   = 8'h30;
  localparam logic [ByteW-1:0] CharNine   = 8'h39;
  localparam logic [ByteW-1:0] CharPlus   = 8'h2b;
  localparam logic [ByteW-1:0] CharSlash  = 8'h2f;
  localparam logic [ByteW-1:0] CharPad    = 8'h3d;

  localparam logic [SextW-1:0] SextLowerBase = 6'd26;
  localparam logic [SextW-1:0] SextDigitBase = 6'd52;
  localparam logic [SextW-1:0] SextPlus      = 6'd62;
  localparam logic [SextW-1:0] SextSlash     = 6'd63;

  // bytes of one item, oldest in data[0]; cnt is 1..3
  typedef struct packed {
    logic [BurstLen-1:0][ByteW-1:0] data;
    logic [1:0]                     cnt;
    logic                           has_data;
    logic                           eom;
  } burst_t;

  typedef struct packed {
    logic             valid;
    logic [SextW-1:0] sextet;
  } sext_t;

  function automatic sext_t char_decode(logic [ByteW-1:0] ch);
    sext_t            r;
    logic [ByteW-1:0] diff;
    r    = '0;
    diff = '0;
    if (ch >= CharUpperA && ch <= CharUpperZ) begin
      diff     = ch - CharUpperA;
      r.valid  = 1'b1;
      r.sextet = diff[SextW-1:0];
    end else if (ch >= CharLowerA && ch <= CharLowerZ) begin
      diff     = ch - CharLowerA;
      r.valid  = 1'b1;
      r.sextet = diff[SextW-1:0] + SextLowerBase;
    end else if (ch >= CharZero && ch <= CharNine) begin
      diff     = ch - CharZero;
      r.valid  = 1'b1;
      r.sextet = diff[SextW-1:0] + SextDigitBase;
    end else if (ch == CharPlus) begin
      r.valid  = 1'b1;
      r.sextet = SextPlus;
    end else if (ch == CharSlash || ch == CharPad) begin
      r.valid  = 1'b1;
      r.sextet = SextSlash;
    end
    return r;
  endfunction

endpackage

[rtl/base64_stream_decoder_unit.sv]
// Base64 stream decoder, top level.
// Slave stream: one ASCII character per item in tdata, tlast marks the final
// character of a message. Characters outside the base64 alphabet are skipped,
// a NUL stops decoding until the final character.
// Master stream: one decoded byte per item in tdata, tuser says whether the
// byte is real (0 for an end-only marker), tlast marks the final result of a
// message.
// Throughput: one character accepted per cycle; each character gives up to
// three bytes, sent one per cycle unless stalled. Characters are taken in every
// cycle while the four-entry burst queue between decode and output is not full,
// which holds at the full input rate for ordinary base64 text.
// Path: a character goes through the input register, is decoded into the
// burst queue, and each of its bytes then passes through the output register.
// Reset clears group state, queue and both handshake registers; no clearing
// pass. When the receiver stalls the output register holds, the queue fills
// and then the slave side deasserts tready.
// Depends on b64d_pkg and b64d_core.
module base64_stream_decoder_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // char_code
  input  logic       s_axis_tlast_i,   // last
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // data_byte
  output logic       m_axis_tuser_o,   // has_data
  output logic       m_axis_tlast_o    // end_of_message
);
  import b64d_pkg::*;

  burst_t            fifo_q [FifoDepth];
  logic [FifoAw-1:0] wr_ptr_q, rd_ptr_q;
  logic [FifoAw:0]   cnt_q;
  logic [1:0]        idx_q;

  logic              push, pop, load, full, last_byte;
  burst_t            push_burst, head;

  logic              m_vld_q;
  logic [ByteW-1:0]  m_data_q;
  logic              m_user_q;
  logic              m_last_q;

  b64d_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .fifo_full_i     (full),
    .push_o          (push),
    .burst_o         (push_burst)
  );

  assign full      = (cnt_q == (FifoAw+1)'(FifoDepth));
  assign head      = fifo_q[rd_ptr_q];
  assign last_byte = (idx_q == head.cnt - 2'd1);
  assign load      = (!m_vld_q || m_axis_tready_i) && (cnt_q != '0);
  assign pop       = load && last_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
      idx_q    <= '0;
      m_vld_q  <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + FifoAw'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + FifoAw'(1);
      end
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + (FifoAw+1)'(1);
        2'b01:   cnt_q <= cnt_q - (FifoAw+1)'(1);
        default: cnt_q <= cnt_q;
      endcase
      if (load) begin
        idx_q <= last_byte ? 2'd0 : idx_q + 2'd1;
      end
      if (load) begin
        m_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= push_burst;
    end
    if (load) begin
      m_data_q <= head.data[idx_q];
      m_user_q <= head.has_data;
      m_last_q <= head.eom && last_byte;
    end
  end

  assign m_axis_tvalid_o = m_vld_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;
  assign m_axis_tlast_o  = m_last_q;

  property p_cnt_bound;
    @(posedge clk_i) disable iff (!rst_ni)
      cnt_q <= (FifoAw+1)'(FifoDepth);
  endproperty
  assert property (p_cnt_bound) else $error("burst queue overflow");

  property p_idx_empty;
    @(posedge clk_i) disable iff (!rst_ni)
      cnt_q == '0 |-> idx_q == 2'd0;
  endproperty
  assert property (p_idx_empty) else $error("byte index left over on empty queue");

  property p_marker_is_end;
    @(posedge clk_i) disable iff (!rst_ni)
      m_vld_q && !m_user_q |-> m_last_q;
  endproperty
  assert property (p_marker_is_end) else $error("end-only marker without tlast");

  property p_no_push_full;
    @(posedge clk_i) disable iff (!rst_ni)
      full |-> !push;
  endproperty
  assert property (p_no_push_full) else $error("push into full burst queue");

endmodule

[rtl/b64d_core.sv]
// input register, group state and decode of one character into a burst of
// up to three bytes; depends on b64d_pkg
module b64d_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  logic [7:0]      s_axis_tdata_i,   // char_code
  input  logic            s_axis_tlast_i,   // last
  input  logic            fifo_full_i,
  output logic            push_o,
  output b64d_pkg::burst_t burst_o
);
  import b64d_pkg::*;

  logic             vld_q;
  logic [ByteW-1:0] ch_q;
  logic             last_q;

  logic [AccW-1:0]  acc_q, acc_d;
  logic [1:0]       gc_q, gc_d;
  logic             tp_q, tp_d;
  logic             st_q, st_d;

  logic             go;
  sext_t            dec;
  logic [WordW-1:0] word;
  burst_t           b;

  assign go              = !fifo_full_i;
  assign s_axis_tready_o = !vld_q || go;
  assign dec             = char_decode(ch_q);

  always_comb begin
    acc_d = acc_q;
    gc_d  = gc_q;
    tp_d  = tp_q;
    st_d  = st_q;
    word  = '0;
    b     = '0;
    b.has_data = 1'b1;
    if (!st_q) begin
      if (ch_q == CharNul) begin
        st_d = 1'b1;
      end else if (dec.valid) begin
        if (gc_q == 2'd3) begin
          word      = {acc_q, dec.sextet};
          b.data[0] = word[23:16];
          if (tp_q) begin
            b.data[1] = word[7:0];
            b.cnt     = (ch_q == CharPad) ? 2'd1 : 2'd2;
          end else begin
            b.data[1] = word[15:8];
            b.data[2] = word[7:0];
            b.cnt     = (ch_q == CharPad) ? 2'd2 : 2'd3;
          end
          acc_d = '0;
          gc_d  = '0;
          tp_d  = 1'b0;
        end else begin
          if (gc_q == 2'd2) begin
            tp_d = (ch_q == CharPad);
          end
          acc_d = {acc_q[AccW-SextW-1:0], dec.sextet};
          gc_d  = gc_q + 2'd1;
        end
      end
    end
    if (last_q) begin
      case (gc_d)
        2'd1:    word = {acc_d[5:0], 18'd0};
        2'd2:    word = {acc_d[11:0], 12'd0};
        2'd3:    word = {acc_d, 6'd0};
        default: word = word;
      endcase
      if (gc_d != 2'd0) begin
        b.data[0] = word[23:16];
        if (gc_d == 2'd3 && tp_d) begin
          b.data[1] = word[7:0];
          b.cnt     = 2'd2;
        end else begin
          b.data[1] = word[15:8];
          b.data[2] = word[7:0];
          b.cnt     = 2'd3;
        end
      end
      if (b.cnt == 2'd0) begin
        b.cnt      = 2'd1;
        b.has_data = 1'b0;
      end
      b.eom = 1'b1;
      acc_d = '0;
      gc_d  = '0;
      tp_d  = 1'b0;
      st_d  = 1'b0;
    end
  end

  assign burst_o = b;
  assign push_o  = vld_q && go && (b.cnt != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      acc_q <= '0;
      gc_q  <= '0;
      tp_q  <= 1'b0;
      st_q  <= 1'b0;
    end else begin
      if (s_axis_tready_o) begin
        vld_q <= s_axis_tvalid_i;
      end
      if (vld_q && go) begin
        acc_q <= acc_d;
        gc_q  <= gc_d;
        tp_q  <= tp_d;
        st_q  <= st_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      ch_q   <= s_axis_tdata_i;
      last_q <= s_axis_tlast_i;
    end
  end

  property p_idle_group_clear;
    @(posedge clk_i) disable iff (!rst_ni)
      vld_q && go && last_q |=> gc_q == 2'd0 && !st_q && !tp_q;
  endproperty
  assert property (p_idle_group_clear) else $error("state not cleared after last item");

  property p_push_on_last;
    @(posedge clk_i) disable iff (!rst_ni)
      vld_q && go && last_q |-> push_o && burst_o.eom;
  endproperty
  assert property (p_push_on_last) else $error("last item gave no final result");

  property p_stopped_no_data;
    @(posedge clk_i) disable iff (!rst_ni)
      vld_q && go && st_q && !last_q |-> !push_o;
  endproperty
  assert property (p_stopped_no_data) else $error("bytes produced while stopped");

endmodule
